[rtl/core/edfd_pkg.sv]
package edfd_pkg;

	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_BSL  = 8'h5C;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;
	localparam logic [1:0] KIND_HDR   = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_ZERO_CNT  = 2'd1;
	localparam logic [1:0] ERR_LONG_CNT  = 2'd2;
	localparam logic [1:0] ERR_AMP_PARAM = 2'd3;

	localparam logic [16:0] MAX17  = 17'h1FFFF;
	localparam logic [15:0] MAX_LEN = 16'hFFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_last;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_out;
		logic [15:0] param_length;
		logic [16:0] param_number;
		logic        message_last;
		logic [16:0] param_count;
		logic [1:0]  error_code;
	} out_t;

	typedef struct packed {
		logic valid;
		out_t beat;
	} res_t;

endpackage

[rtl/core/edfd_parse.sv]
module edfd_parse #(
	parameter int COUNT_CHARS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  edfd_pkg::in_t  in_beat,
	output edfd_pkg::res_t res
);

	localparam int DCW = $clog2(COUNT_CHARS + 1);
	localparam logic [DCW-1:0] DC_MAX = DCW'(COUNT_CHARS);

	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_PARAM = 2'd2;

	logic [1:0]     phase_q, phase_n;
	logic           amp_q, amp_n;
	logic           esc_q, esc_n;
	logic           disc_q, disc_n;
	logic [DCW-1:0] dchars_q, dchars_n;
	logic           dstop_q, dstop_n;
	logic [16:0]    count_q, count_n;
	logic [16:0]    left_q, left_n;
	logic [15:0]    len_q, len_n;
	logic [16:0]    idx_q, idx_n;

	logic [7:0]  b;
	logic        last;
	logic        is_digit;
	logic [20:0] count_mul;
	logic        go_hunt;
	logic        done;

	assign b = in_beat.data_byte;
	assign last = in_beat.chunk_last;
	assign is_digit = b inside {[edfd_pkg::CH_ZERO:edfd_pkg::CH_NINE]};
	assign count_mul = {count_q, 3'b000} + {2'b00, count_q, 1'b0}
		+ {17'd0, b[3:0] - 4'd0};
	assign done = left_q <= 17'd1;

	always_comb begin
		phase_n  = phase_q;
		amp_n    = amp_q;
		esc_n    = esc_q;
		disc_n   = disc_q;
		dchars_n = dchars_q;
		dstop_n  = dstop_q;
		count_n  = count_q;
		left_n   = left_q;
		len_n    = len_q;
		idx_n    = idx_q;
		go_hunt  = 1'b0;
		res      = '0;
		if (disc_q) begin
			if (last) begin
				disc_n = 1'b0;
			end
		end else begin
			case (phase_q)
				PH_HUNT: begin
					if (amp_q) begin
						if (b == edfd_pkg::CH_SEMI) begin
							amp_n    = 1'b0;
							phase_n  = PH_LEN;
							dchars_n = '0;
							dstop_n  = 1'b0;
							count_n  = '0;
						end else if (b != edfd_pkg::CH_AMP) begin
							amp_n = 1'b0;
						end
					end else if (b == edfd_pkg::CH_AMP) begin
						amp_n = 1'b1;
					end
				end
				PH_LEN: begin
					if (b == edfd_pkg::CH_SEMI) begin
						if (count_q == 17'd0) begin
							go_hunt = 1'b1;
							disc_n = !last;
							res.valid = 1'b1;
							res.beat.kind = edfd_pkg::KIND_ERROR;
							res.beat.error_code = edfd_pkg::ERR_ZERO_CNT;
						end else begin
							left_n  = count_q - 17'd1;
							len_n   = '0;
							idx_n   = '0;
							esc_n   = 1'b0;
							phase_n = PH_PARAM;
							res.valid = 1'b1;
							res.beat.kind = edfd_pkg::KIND_HDR;
							res.beat.param_count = count_q - 17'd1;
						end
					end else begin
						if (!dstop_q && is_digit) begin
							if (count_mul[20:17] != 4'd0) begin
								count_n = edfd_pkg::MAX17;
							end else begin
								count_n = count_mul[16:0];
							end
						end else begin
							dstop_n = 1'b1;
						end
						if (dchars_q >= DC_MAX) begin
							go_hunt = 1'b1;
							disc_n = !last;
							res.valid = 1'b1;
							res.beat.kind = edfd_pkg::KIND_ERROR;
							res.beat.error_code = edfd_pkg::ERR_LONG_CNT;
						end else begin
							dchars_n = dchars_q + DCW'(1);
						end
					end
				end
				PH_PARAM: begin
					if (!esc_q && b == edfd_pkg::CH_SEMI) begin
						res.valid = 1'b1;
						res.beat.kind = edfd_pkg::KIND_END;
						res.beat.param_length = len_q;
						res.beat.param_number = idx_q;
						res.beat.message_last = done;
						if (done) begin
							go_hunt = 1'b1;
						end else begin
							left_n = left_q - 17'd1;
							idx_n  = idx_q + 17'd1;
							len_n  = '0;
						end
					end else if (!esc_q && b == edfd_pkg::CH_BSL) begin
						esc_n = 1'b1;
					end else if (!esc_q && b == edfd_pkg::CH_AMP) begin
						go_hunt = 1'b1;
						disc_n = !last;
						res.valid = 1'b1;
						res.beat.kind = edfd_pkg::KIND_ERROR;
						res.beat.error_code = edfd_pkg::ERR_AMP_PARAM;
					end else begin
						esc_n = 1'b0;
						res.valid = 1'b1;
						res.beat.kind = edfd_pkg::KIND_BYTE;
						res.beat.data_out = b;
						res.beat.param_number = idx_q;
						if (len_q != edfd_pkg::MAX_LEN) begin
							len_n = len_q + 16'd1;
						end
					end
				end
				default: begin
					go_hunt = 1'b1;
				end
			endcase
		end
		if (go_hunt) begin
			phase_n  = PH_HUNT;
			amp_n    = 1'b0;
			esc_n    = 1'b0;
			dchars_n = '0;
			dstop_n  = 1'b0;
			count_n  = '0;
			left_n   = '0;
			len_n    = '0;
			idx_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			amp_q    <= 1'b0;
			esc_q    <= 1'b0;
			disc_q   <= 1'b0;
			dchars_q <= '0;
			dstop_q  <= 1'b0;
			count_q  <= '0;
			left_q   <= '0;
			len_q    <= '0;
			idx_q    <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			amp_q    <= amp_n;
			esc_q    <= esc_n;
			disc_q   <= disc_n;
			dchars_q <= dchars_n;
			dstop_q  <= dstop_n;
			count_q  <= count_n;
			left_q   <= left_n;
			len_q    <= len_n;
			idx_q    <= idx_n;
		end
	end

	a_disc_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> phase_q == PH_HUNT)
		else $error("discarding outside header hunt");

	a_esc_param: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> phase_q == PH_PARAM)
		else $error("escape pending outside parameter");

	a_amp_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		amp_q |-> phase_q == PH_HUNT)
		else $error("ampersand armed outside header hunt");

	a_dchars: assert property (@(posedge clk) disable iff (!arst_n)
		dchars_q <= DC_MAX)
		else $error("count field length overrun");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(phase_q) && $stable(idx_q) && $stable(len_q))
		else $error("parser state moved without a beat");

endmodule

[rtl/core/edfd_out_reg.sv]
module edfd_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  edfd_pkg::res_t res,
	output logic           fire,
	output logic           out_valid,
	input  logic           out_ready,
	output edfd_pkg::out_t out_data
);

	logic           valid_q;
	edfd_pkg::out_t data_q;
	logic           load;

	assign load = !valid_q || out_ready;
	assign in_ready = load;
	assign fire = in_valid && load;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			data_q <= res.beat;
		end
	end

endmodule

[rtl/core/escaped_field_message_deframer_top.sv]
// output: a result is registered and appears in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle; the single output register is reloaded
// in the same cycle that its beat is taken, so input stalls only on output backpressure
// reset: arst_n clears the parser to header hunt and empties the output register
module escaped_field_message_deframer_top #(
	parameter int COUNT_CHARS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  edfd_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output edfd_pkg::out_t out_data
);

	edfd_pkg::res_t res;
	logic           fire;

	edfd_parse #(
		.COUNT_CHARS(COUNT_CHARS)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.in_beat(in_data),
		.res(res)
	);

	edfd_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.res(res),
		.fire(fire),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

[test/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_LIMIT = 5;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 350;

	class frame_checker;
		typedef enum logic [1:0] {HUNT, COUNT_FIELD, PARAMS} phase_e;

		phase_e phase;
		bit armed;
		bit escaped;
		bit dropping;
		bit stopped;
		int unsigned chars_seen;
		int unsigned count_value;
		int unsigned params_left;
		int unsigned index;
		int unsigned length;
		edfd_pkg::out_t expected[$];
		int errors;

		function new();
			dropping = 1'b0;
			errors = 0;
			go_hunt();
		endfunction

		function void go_hunt();
			phase = HUNT;
			armed = 1'b0;
			escaped = 1'b0;
			stopped = 1'b0;
			chars_seen = 0;
			count_value = 0;
			params_left = 0;
			length = 0;
			index = 0;
		endfunction

		function edfd_pkg::out_t error_beat(logic [1:0] code, logic last);
			edfd_pkg::out_t r;
			r = '0;
			go_hunt();
			dropping = !last;
			r.kind = edfd_pkg::KIND_ERROR;
			r.error_code = code;
			return r;
		endfunction

		function edfd_pkg::out_t data_beat(logic [7:0] b);
			edfd_pkg::out_t r;
			r = '0;
			r.kind = edfd_pkg::KIND_BYTE;
			r.data_out = b;
			r.param_number = 17'(index);
			if (length < edfd_pkg::MAX_LEN)
				length++;
			return r;
		endfunction

		function void note_byte(edfd_pkg::in_t item);
			edfd_pkg::out_t r;
			bit has;
			bit done;
			logic [7:0] b;
			r = '0;
			has = 1'b0;
			b = item.data_byte;
			if (dropping) begin
				if (item.chunk_last)
					dropping = 1'b0;
			end else if (phase == HUNT) begin
				if (armed) begin
					if (b == edfd_pkg::CH_SEMI) begin
						go_hunt();
						phase = COUNT_FIELD;
					end else if (b != edfd_pkg::CH_AMP) begin
						armed = 1'b0;
					end
				end else if (b == edfd_pkg::CH_AMP) begin
					armed = 1'b1;
				end
			end else if (phase == COUNT_FIELD) begin
				if (b == edfd_pkg::CH_SEMI) begin
					has = 1'b1;
					if (count_value == 0) begin
						r = error_beat(edfd_pkg::ERR_ZERO_CNT, item.chunk_last);
					end else begin
						params_left = count_value - 1;
						length = 0;
						index = 0;
						escaped = 1'b0;
						phase = PARAMS;
						r.kind = edfd_pkg::KIND_HDR;
						r.param_count = 17'(params_left);
					end
				end else begin
					if (!stopped && b >= edfd_pkg::CH_ZERO && b <= edfd_pkg::CH_NINE) begin
						count_value = count_value * 10 + (b - edfd_pkg::CH_ZERO);
						if (count_value > edfd_pkg::MAX17)
							count_value = edfd_pkg::MAX17;
					end else begin
						stopped = 1'b1;
					end
					if (chars_seen >= COUNT_LIMIT) begin
						r = error_beat(edfd_pkg::ERR_LONG_CNT, item.chunk_last);
						has = 1'b1;
					end else begin
						chars_seen++;
					end
				end
			end else begin
				if (escaped) begin
					escaped = 1'b0;
					r = data_beat(b);
					has = 1'b1;
				end else if (b == edfd_pkg::CH_SEMI) begin
					done = params_left <= 1;
					r.kind = edfd_pkg::KIND_END;
					r.param_length = 16'(length);
					r.param_number = 17'(index);
					r.message_last = done;
					has = 1'b1;
					if (done) begin
						go_hunt();
					end else begin
						params_left--;
						index = (index + 1) & edfd_pkg::MAX17;
						length = 0;
					end
				end else if (b == edfd_pkg::CH_BSL) begin
					escaped = 1'b1;
				end else if (b == edfd_pkg::CH_AMP) begin
					r = error_beat(edfd_pkg::ERR_AMP_PARAM, item.chunk_last);
					has = 1'b1;
				end else begin
					r = data_beat(b);
					has = 1'b1;
				end
			end
			if (has)
				expected.push_back(r);
		endfunction

		function void check_beat(edfd_pkg::out_t got);
			edfd_pkg::out_t want;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display({"unexpected beat: kind %0d data %02h len %0d",
						" num %0d last %0d cnt %0d err %0d"},
						got.kind, got.data_out, got.param_length, got.param_number,
						got.message_last, got.param_count, got.error_code);
				return;
			end
			want = expected.pop_front();
			if (got.kind !== want.kind || got.data_out !== want.data_out ||
				got.param_length !== want.param_length ||
				got.param_number !== want.param_number ||
				got.message_last !== want.message_last ||
				got.param_count !== want.param_count ||
				got.error_code !== want.error_code) begin
				errors++;
				if (errors <= 10) begin
					$display({"mismatch at %0t: expected kind %0d data %02h len %0d",
						" num %0d last %0d cnt %0d err %0d"},
						$realtime, want.kind, want.data_out, want.param_length,
						want.param_number, want.message_last, want.param_count,
						want.error_code);
					$display("  got kind %0d data %02h len %0d num %0d last %0d cnt %0d err %0d",
						got.kind, got.data_out, got.param_length, got.param_number,
						got.message_last, got.param_count, got.error_code);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	edfd_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	edfd_pkg::out_t out_data;

	frame_checker sb = new();
	int send_idle_pct;
	int recv_idle_pct;
	int sent;
	int quiet;
	int hold_left;
	bit hold_req;

	escaped_field_message_deframer_top #(
		.COUNT_CHARS(COUNT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// receiver: random backpressure, plus a long hold when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			sb.note_byte(in_data);
			quiet = 0;
		end
		if (out_valid && out_ready) begin
			sb.check_beat(out_data);
			quiet = 0;
		end else if (!(in_valid && in_ready)) begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("escaped_field_message_deframer_top test failed");
				$finish;
			end
		end
	end

	function automatic logic rand_last();
		return $urandom_range(9) == 0;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, chunk_last: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_at_end && i == s.len() - 1);
	endtask

	task automatic stop_and_drain();
		in_valid <= 1'b0;
		while (sb.expected.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_param(output bit aborted);
		int len;
		logic [7:0] b;
		aborted = 1'b0;
		len = $urandom_range(0, 6);
		for (int i = 0; i < len && !aborted; i++) begin
			b = 8'($urandom_range(255));
			if ($urandom_range(5) == 0) begin
				case ($urandom_range(2))
					0: b = edfd_pkg::CH_SEMI;
					1: b = edfd_pkg::CH_AMP;
					default: b = edfd_pkg::CH_BSL;
				endcase
			end
			if (b == edfd_pkg::CH_AMP && $urandom_range(3) == 0) begin
				send_byte(b, rand_last());
				aborted = 1'b1;
			end else if (b == edfd_pkg::CH_SEMI || b == edfd_pkg::CH_AMP ||
				b == edfd_pkg::CH_BSL || $urandom_range(15) == 0) begin
				send_byte(edfd_pkg::CH_BSL, rand_last());
				send_byte(b, rand_last());
			end else begin
				send_byte(b, rand_last());
			end
		end
		if (!aborted)
			send_byte(edfd_pkg::CH_SEMI, rand_last());
	endtask

	task automatic send_message();
		int sel;
		int n;
		int nparams;
		string digits;
		logic [7:0] c;
		bit aborted;
		aborted = 1'b0;
		n = 1;
		repeat ($urandom_range(0, 2))
			send_byte(8'($urandom_range(255)), rand_last());
		if ($urandom_range(7) == 0)
			send_byte(edfd_pkg::CH_AMP, rand_last());
		send_byte(edfd_pkg::CH_AMP, rand_last());
		send_byte(edfd_pkg::CH_SEMI, rand_last());
		sel = $urandom_range(99);
		if (sel < 75) begin
			n = $urandom_range(1, 5);
			digits = $sformatf("%0d", n);
			if ($urandom_range(3) == 0)
				digits = {"00", digits};
			if ($urandom_range(4) == 0)
				digits = {digits, "q"};
			send_text(digits, 1'b0);
			send_byte(edfd_pkg::CH_SEMI, rand_last());
		end else if (sel < 83) begin
			// zero count in its various spellings
			case ($urandom_range(3))
				0: send_text("0", 1'b0);
				1: ;
				2: send_text("000", 1'b0);
				default: send_text("x7", 1'b0);
			endcase
			send_byte(edfd_pkg::CH_SEMI, rand_last());
			aborted = 1'b1;
		end else if (sel < 91) begin
			repeat (COUNT_LIMIT + 1) begin
				c = $urandom_range(1) ? 8'($urandom_range(48, 57))
					: 8'($urandom_range(97, 122));
				send_byte(c, 1'b0);
			end
			aborted = 1'b1;
		end else begin
			n = $urandom_range(6, 99999);
			send_text($sformatf("%0d", n), 1'b0);
			send_byte(edfd_pkg::CH_SEMI, rand_last());
		end
		if (!aborted) begin
			nparams = (n > 1) ? n - 1 : 1;
			if (sel >= 91)
				nparams = 2;
			for (int p = 0; p < nparams && !aborted; p++)
				send_param(aborted);
			// big counts never finish, end them with a bare ampersand
			if (sel >= 91 && !aborted) begin
				send_byte(edfd_pkg::CH_AMP, rand_last());
				aborted = 1'b1;
			end
		end
		if (aborted) begin
			repeat ($urandom_range(0, 2))
				send_byte(8'($urandom_range(255)), 1'b0);
			send_byte(8'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic run_traffic(input int target);
		int start;
		bit held;
		start = sent;
		held = 1'b0;
		while (sent - start < target) begin
			if (!held && sent - start >= target / 2) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			send_message();
		end
		stop_and_drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent = 0;
		quiet = 0;
		hold_left = 0;
		hold_req = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: repeated ampersand, escapes, byte extremes
		send_text("&&;3;", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("\\;;\\&;", 1'b0);
		// empty count
		send_text("&;;", 1'b1);
		// stopped digits, then bare ampersand in a parameter
		send_text("&;1x;&", 1'b1);
		// count field too long, rest of chunk dropped
		send_text("&;123456x", 1'b0);
		send_text("y", 1'b1);
		stop_and_drain();

		send_idle_pct = 27;
		recv_idle_pct = 79;
		run_traffic(PHASE_BYTES);
		send_idle_pct = 79;
		recv_idle_pct = 27;
		run_traffic(PHASE_BYTES);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_traffic(PHASE_BYTES);

		// largest count, aborted by a bare ampersand
		send_text("&;99999;", 1'b0);
		send_byte(edfd_pkg::CH_AMP, 1'b1);
		stop_and_drain();

		repeat (4) @(posedge clk);
		if (sb.errors == 0) begin
			$display("escaped_field_message_deframer_top test passed");
		end else begin
			$display("escaped_field_message_deframer_top test failed");
		end
		$finish;
	end

endmodule
